// ----- src/lfsc_pkg.sv -----
package lfsc_pkg;

	// sample counter width
	localparam int TIME_W = 16;
	// width used for the window compare, wide enough for any TIME_W in 8..32
	localparam int CMP_W = 33;

	localparam int DIV_W = 16;
	localparam int WIN_W = 16;
	localparam int LIM_W = 8;
	localparam int HITS_W = 8;

	localparam logic [DIV_W-1:0] TICK_DIVIDE_RST = DIV_W'(100);
	localparam logic [WIN_W-1:0] SIGNAL_WINDOW_RST = WIN_W'(500);
	localparam logic [LIM_W-1:0] STOP_LIMIT_RST = LIM_W'(93);
	localparam logic [HITS_W-1:0] HITS_MAX = '1;

	// configuration register indexes
	localparam logic [1:0] CFG_TICK_DIVIDE = 2'd0;
	localparam logic [1:0] CFG_SIGNAL_WINDOW = 2'd1;
	localparam logic [1:0] CFG_STOP_LIMIT = 2'd2;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// phase patterns
	localparam logic [3:0] PH_RESTART = 4'hC;

	typedef enum logic [2:0] {
		HD_FWD = 3'd0,
		HD_LEFT = 3'd1,
		HD_RIGHT = 3'd2,
		HD_SPIN_R = 3'd3,
		HD_SPIN_L = 3'd4
	} heading_t;

	typedef struct packed {
		logic [DIV_W-1:0] tick_divide;
		logic [WIN_W-1:0] signal_window;
		logic [LIM_W-1:0] stop_limit;
	} cfg_t;

	typedef struct packed {
		logic command;
		logic [3:0] sensors;
	} item_t;

	typedef struct packed {
		logic running;
		logic stepped;
		logic [2:0] heading;
		logic [7:0] coil_drive;
	} result_t;

	// one half step; up walks 1-3-2-6-4-C-8-9
	function automatic logic [3:0] half_step(input logic [3:0] p, input logic up);
		logic [3:0] n;
		unique case (p)
			4'h9: n = up ? 4'h1 : 4'h8;
			4'h1: n = up ? 4'h3 : 4'h9;
			4'h3: n = up ? 4'h2 : 4'h1;
			4'h2: n = up ? 4'h6 : 4'h3;
			4'h6: n = up ? 4'h4 : 4'h2;
			4'h4: n = up ? 4'hC : 4'h6;
			4'hC: n = up ? 4'h8 : 4'h4;
			4'h8: n = up ? 4'h9 : 4'hC;
			default: n = PH_RESTART;
		endcase
		return n;
	endfunction

endpackage

// ----- src/lfsc_core.sv -----
module lfsc_core
	import lfsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [DIV_W-1:0]  prescale_q;
	logic [TIME_W-1:0] sample_cnt_q;
	heading_t          rem_sig_q;
	logic [TIME_W-1:0] sig_time_q;
	logic [HITS_W-1:0] hits_q;
	logic              run_q;
	logic [3:0]        left_q;
	logic [3:0]        right_q;
	heading_t          last_hd_q;

	logic [DIV_W-1:0]  prescale_d;
	logic [TIME_W-1:0] sample_cnt_d;
	heading_t          rem_sig_d;
	logic [TIME_W-1:0] sig_time_d;
	logic [HITS_W-1:0] hits_d;
	logic              run_d;
	logic [3:0]        left_d;
	logic [3:0]        right_d;
	heading_t          last_hd_d;
	logic              stepped;

	logic [DIV_W-1:0]  prescale_inc;
	logic [TIME_W-1:0] sample_inc;
	logic [TIME_W-1:0] age;
	logic              in_window;
	logic [HITS_W-1:0] hits_inc;
	heading_t          hd;
	logic              stop;

	assign prescale_inc = prescale_q + DIV_W'(1);
	assign sample_inc = sample_cnt_q + TIME_W'(1);
	assign age = sample_inc - sig_time_q;
	assign in_window = CMP_W'(age) < CMP_W'(cfg.signal_window);
	assign hits_inc = (hits_q == HITS_MAX) ? hits_q : hits_q + HITS_W'(1);

	always_comb begin
		prescale_d = prescale_q;
		sample_cnt_d = sample_cnt_q;
		rem_sig_d = rem_sig_q;
		sig_time_d = sig_time_q;
		hits_d = hits_q;
		run_d = run_q;
		left_d = left_q;
		right_d = right_q;
		last_hd_d = last_hd_q;
		stepped = 1'b0;
		hd = HD_FWD;
		stop = 1'b0;

		if (item.command == CMD_RESTART) begin
			run_d = 1'b1;
			hits_d = '0;
		end else if (run_q) begin
			if (prescale_inc >= cfg.tick_divide) begin
				prescale_d = '0;
				stepped = 1'b1;
				sample_cnt_d = sample_inc;
				unique case (item.sensors)
					4'h0: if (in_window) begin
						hd = rem_sig_q;
					end
					4'h2, 4'hA: begin
						hd = HD_LEFT;
						rem_sig_d = HD_SPIN_R;
						sig_time_d = sample_inc;
					end
					4'h3, 4'hB: hd = HD_LEFT;
					4'h4, 4'h5: begin
						hd = HD_RIGHT;
						rem_sig_d = HD_SPIN_L;
						sig_time_d = sample_inc;
					end
					4'hC, 4'hD: hd = HD_RIGHT;
					4'h6: begin
						hits_d = hits_inc;
						stop = hits_inc > cfg.stop_limit;
					end
					4'h7: begin
						rem_sig_d = HD_SPIN_L;
						sig_time_d = sample_inc;
					end
					4'hE: begin
						rem_sig_d = HD_SPIN_R;
						sig_time_d = sample_inc;
					end
					default: hd = HD_FWD;
				endcase

				if (stop) begin
					// stopping sample holds the phases
					last_hd_d = HD_FWD;
					run_d = 1'b0;
				end else begin
					last_hd_d = hd;
					unique case (hd)
						HD_FWD: begin
							right_d = half_step(right_q, 1'b1);
							left_d = half_step(left_q, 1'b0);
						end
						HD_LEFT: left_d = half_step(left_q, 1'b0);
						HD_RIGHT: right_d = half_step(right_q, 1'b1);
						HD_SPIN_R: begin
							right_d = half_step(right_q, 1'b1);
							left_d = half_step(left_q, 1'b1);
						end
						HD_SPIN_L: begin
							left_d = half_step(left_q, 1'b0);
							right_d = half_step(right_q, 1'b0);
						end
						default: begin
							left_d = left_q;
							right_d = right_q;
						end
					endcase
				end
			end else begin
				prescale_d = prescale_inc;
			end
		end

		result.running = run_d;
		result.stepped = stepped;
		result.heading = last_hd_d;
		result.coil_drive = run_d ? {right_d, left_d} : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			sample_cnt_q <= '0;
			rem_sig_q <= HD_FWD;
			sig_time_q <= '0;
			hits_q <= '0;
			run_q <= 1'b0;
			left_q <= '0;
			right_q <= '0;
			last_hd_q <= HD_FWD;
		end else if (fire) begin
			prescale_q <= prescale_d;
			sample_cnt_q <= sample_cnt_d;
			rem_sig_q <= rem_sig_d;
			sig_time_q <= sig_time_d;
			hits_q <= hits_d;
			run_q <= run_d;
			left_q <= left_d;
			right_q <= right_d;
			last_hd_q <= last_hd_d;
		end
	end

endmodule

// ----- src/line_follow_stepper_controller.sv -----
// line follower with half-step stepper drive
//
// input stream: one request per timer tick or restart. s_tuser carries the
// command (0 tick, 1 restart), s_tdata[3:0] the four line sensor bits.
// output stream: exactly one result per request, in order. m_tdata packs
// coil_drive, heading, stepped and running from the low bit up.
// config channel: cfg_index selects tick_divide (0), signal_window (1) or
// stop_limit (2); other indexes are accepted and dropped. cfg_ready is
// always high. write only while no request is in flight.
//
// a request is accepted into the input register and its result is
// loaded into the output register, which raises m_tvalid, once the
// output slot is free.
// throughput: one request per cycle while the receiver takes results;
// the state update between the two registers is combinational.
// when the receiver stalls the output register holds and the input
// register still takes one more request; s_tready drops only when both
// are full. reset empties both registers, loads the register defaults
// (100, 500, 93) and leaves the controller stopped until a restart.
module line_follow_stepper_controller
	import lfsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] sensors, [7:4] zero
	input  logic        s_tuser,   // [0] command
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] coil_drive, [10:8] heading, [11] stepped,
	                               // [12] running, [15:13] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// input register
	logic    valid_s1;
	item_t   item_s1;
	// output register
	logic    out_valid_q;
	result_t out_q;
	// configuration registers
	cfg_t    cfg_q;

	result_t result;
	logic    advance;

	// the item in the input register moves on when the output slot frees up
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command <= s_tuser;
			item_s1.sensors <= s_tdata[3:0];
		end
	end

	// per-request state update and result
	lfsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divide <= TICK_DIVIDE_RST;
			cfg_q.signal_window <= SIGNAL_WINDOW_RST;
			cfg_q.stop_limit <= STOP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICK_DIVIDE: cfg_q.tick_divide <= cfg_data;
				CFG_SIGNAL_WINDOW: cfg_q.signal_window <= cfg_data;
				CFG_STOP_LIMIT: cfg_q.stop_limit <= cfg_data[LIM_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// coils are never energized while stopped
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12] || m_tdata[7:0] == 8'h00))
		else $error("coil drive nonzero while stopped");

	// heading stays within the five codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:8] <= 3'd4))
		else $error("heading out of range");

	// a restart reports running and never steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.command == CMD_RESTART) |=>
		(m_tvalid && m_tdata[12] && !m_tdata[11]))
		else $error("restart result wrong");

	// a pending request is not lost while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register dropped a request");

endmodule

// ----- test/line_follow_stepper_controller_test.sv -----
`timescale 1ns / 1ps

module line_follow_stepper_controller_test
	import lfsc_pkg::*;
();

	// cycles with no handshake of any kind before the run is called hung
	localparam int IDLE_LIMIT = 5000;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 240;
	// index that the block accepts and drops
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	// half-step ring in the up direction, entry i in bits [4i+3:4i]
	localparam logic [31:0] STEP_RING = 32'h98C46231;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_COMB
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	line_follow_stepper_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// controller copy: settings
	logic [DIV_W-1:0] div_reg = TICK_DIVIDE_RST;
	logic [WIN_W-1:0] win_reg = SIGNAL_WINDOW_RST;
	logic [LIM_W-1:0] lim_reg = STOP_LIMIT_RST;
	// controller copy: state
	logic [DIV_W-1:0] tick_count = '0;
	logic [TIME_W-1:0] sample_no = '0;
	logic [TIME_W-1:0] memo_time = '0;
	heading_t memo_sig = HD_FWD;
	heading_t last_hd = HD_FWD;
	logic [HITS_W-1:0] hits = '0;
	logic run = 1'b0;
	logic [3:0] lph = '0;
	logic [3:0] rph = '0;

	// coil drive and status still owed by the block, oldest first
	result_t drive_q[$];

	int errors = 0;
	int requests = 0;
	int results = 0;
	int samples = 0;
	int stops = 0;
	int quiet_cycles = 0;

	// sender and receiver pacing
	int burst_left = 0;
	int gap_max = 0;
	rx_mode_t rx_mode = RX_OPEN;
	logic hold_start = 1'b0;
	int hold_left = 0;
	int comb_phase = 0;

	// next half step; anything off the ring restarts at C
	function automatic logic [3:0] next_phase(input logic [3:0] p, input logic up);
		int pos;
		pos = -1;
		for (int i = 0; i < 8; i++)
			if (STEP_RING[4*i +: 4] == p)
				pos = i;
		if (pos < 0)
			return PH_RESTART;
		return up ? STEP_RING[4*((pos + 1) % 8) +: 4] : STEP_RING[4*((pos + 7) % 8) +: 4];
	endfunction

	// advance the controller copy by one request and return its result
	function automatic result_t drive_step(input logic cmd, input logic [3:0] sens);
		result_t r;
		heading_t h;
		logic stepped;
		logic halted;
		logic [TIME_W-1:0] age;
		stepped = 1'b0;
		halted = 1'b0;
		h = HD_FWD;
		if (cmd == CMD_RESTART) begin
			run = 1'b1;
			hits = '0;
		end else if (run) begin
			tick_count = tick_count + 1'b1;
			if (tick_count >= div_reg) begin
				tick_count = '0;
				stepped = 1'b1;
				sample_no = sample_no + 1'b1;
				age = sample_no - memo_time;
				case (sens)
				4'h0: if (age < win_reg) h = memo_sig;        // crossing, replay in window
				4'h2, 4'hA: begin
					h = HD_LEFT;
					memo_sig = HD_SPIN_R;
					memo_time = sample_no;
				end
				4'h3, 4'hB: h = HD_LEFT;
				4'h4, 4'h5: begin
					h = HD_RIGHT;
					memo_sig = HD_SPIN_L;
					memo_time = sample_no;
				end
				4'hC, 4'hD: h = HD_RIGHT;
				4'h6: begin                                   // centre hit
					if (hits != HITS_MAX)
						hits = hits + 1'b1;
					if (hits > lim_reg) begin
						halted = 1'b1;
						run = 1'b0;
					end
				end
				4'h7: begin
					memo_sig = HD_SPIN_L;
					memo_time = sample_no;
				end
				4'hE: begin
					memo_sig = HD_SPIN_R;
					memo_time = sample_no;
				end
				default: ;
				endcase
				if (halted) begin
					last_hd = HD_FWD;
				end else begin
					last_hd = h;
					case (h)
					HD_FWD: begin
						rph = next_phase(rph, 1'b1);
						lph = next_phase(lph, 1'b0);
					end
					HD_LEFT: lph = next_phase(lph, 1'b0);
					HD_RIGHT: rph = next_phase(rph, 1'b1);
					HD_SPIN_R: begin
						rph = next_phase(rph, 1'b1);
						lph = next_phase(lph, 1'b1);
					end
					HD_SPIN_L: begin
						lph = next_phase(lph, 1'b0);
						rph = next_phase(rph, 1'b0);
					end
					default: ;
					endcase
				end
			end
		end
		r.coil_drive = run ? {rph, lph} : 8'h00;
		r.heading = last_hd;
		r.stepped = stepped;
		r.running = run;
		return r;
	endfunction

	// result check first, then the request taken at this edge
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			results++;
			if (drive_q.size() == 0) begin
				$error("result with no request outstanding: m_tdata %h", m_tdata);
				errors++;
			end else begin
				want = drive_q.pop_front();
				if (m_tdata[7:0] !== want.coil_drive) begin
					$error("coil_drive expected %h got %h", want.coil_drive, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[10:8] !== want.heading) begin
					$error("heading expected %0d got %0d", want.heading, m_tdata[10:8]);
					errors++;
				end
				if (m_tdata[11] !== want.stepped) begin
					$error("stepped expected %b got %b", want.stepped, m_tdata[11]);
					errors++;
				end
				if (m_tdata[12] !== want.running) begin
					$error("running expected %b got %b", want.running, m_tdata[12]);
					errors++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			want = drive_step(s_tuser, s_tdata[3:0]);
			drive_q.push_back(want);
			requests++;
			if (want.stepped) samples++;
			if (want.stepped && !want.running) stops++;
		end
	end

	// hang detection
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("line_follow_stepper_controller verification failed");
			$finish;
		end
	end

	// receiver: long hold-off on request, else the current stall pattern
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
			default: begin
				comb_phase++;
				m_tready <= ((comb_phase % 5) < 3);
			end
			endcase
		end
	end

	// offer one request, starting at a falling edge; returns at the falling
	// edge after acceptance with tvalid still high
	task automatic send_item(input logic cmd, input logic [3:0] sens);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0000, sens};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (drive_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_TICK_DIVIDE: div_reg = val;
		CFG_SIGNAL_WINDOW: win_reg = val;
		CFG_STOP_LIMIT: lim_reg = val[LIM_W-1:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	// all registers, plus a dropped write to the spare index; block idle
	task automatic load_settings(input logic [15:0] div, input logic [15:0] win,
			input logic [15:0] lim);
		put_reg(CFG_TICK_DIVIDE, div);
		put_reg(CFG_SIGNAL_WINDOW, win);
		put_reg(CFG_STOP_LIMIT, lim);
		put_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// ticks before any restart are dropped; default divide gives no sample
	task automatic test_stopped_ticks();
		send_item(CMD_TICK, 4'hF);
		send_item(CMD_TICK, 4'h6);
		send_item(CMD_TICK, 4'h0);
		send_item(CMD_RESTART, 4'h5);
		send_item(CMD_TICK, 4'hA);
		send_item(CMD_TICK, 4'h6);
		settle();
	endtask

	// every sensor pattern, crossing replay inside and outside the window,
	// restart while running
	task automatic test_heading_table();
		load_settings(16'd1, 16'd4, 16'd255);
		send_item(CMD_RESTART, 4'h0);
		for (int s = 0; s < 16; s++) begin
			if (s == 8)
				send_item(CMD_RESTART, 4'hF);
			send_item(CMD_TICK, 4'(s));
		end
		send_item(CMD_TICK, 4'h2);
		repeat (4) send_item(CMD_TICK, 4'h0);
		send_item(CMD_TICK, 4'h4);
		send_item(CMD_TICK, 4'h0);
		settle();
	endtask

	// zero limit: first centre hit stops and blanks the coils
	task automatic test_centre_stop();
		load_settings(16'd1, 16'd0, 16'hFF00);
		send_item(CMD_RESTART, 4'h0);
		send_item(CMD_TICK, 4'h6);
		send_item(CMD_TICK, 4'h1);
		send_item(CMD_RESTART, 4'h0);
		send_item(CMD_TICK, 4'h2);
		send_item(CMD_TICK, 4'h6);
		send_item(CMD_RESTART, 4'h0);
		send_item(CMD_RESTART, 4'h0);
		send_item(CMD_TICK, 4'h0);
		settle();
	endtask

	// zero divide samples every tick; lowering below the count samples next
	task automatic test_prescale_edges();
		load_settings(16'd0, 16'hFFFF, 16'd255);
		send_item(CMD_RESTART, 4'h0);
		repeat (4) send_item(CMD_TICK, 4'($urandom));
		settle();
		load_settings(16'd50, 16'hFFFF, 16'd255);
		repeat (10) send_item(CMD_TICK, 4'($urandom));
		settle();
		load_settings(16'd3, 16'hFFFF, 16'd255);
		repeat (3) send_item(CMD_TICK, 4'($urandom));
		settle();
	endtask

	// receiver holds off long enough for both stages to fill and stall input
	task automatic test_backpressure();
		load_settings(16'd1, 16'd20, 16'd255);
		rx_mode = RX_OPEN;
		gap_max = 0;
		hold_start = 1'b1;
		send_item(CMD_RESTART, 4'h0);
		repeat (40) send_item(CMD_TICK, 4'($urandom));
		settle();
	endtask

	// random tick streams, weighted toward crossings and centre hits;
	// restarts come often while stopped, rarely while running
	task automatic test_random_run(input logic [15:0] div, input logic [15:0] win,
			input logic [15:0] lim, input int count, input rx_mode_t mode, input int gap);
		int pick;
		logic [3:0] sens;
		rx_mode = mode;
		gap_max = gap;
		load_settings(div, win, lim);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				sens = 4'h0;
			else if (pick < 38)
				sens = 4'h6;
			else
				sens = 4'($urandom);
			if ($urandom_range(0, 99) < (run ? 3 : 30))
				send_item(CMD_RESTART, sens);
			else
				send_item(CMD_TICK, sens);
		end
		settle();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_max = 2;
		test_stopped_ticks();
		test_heading_table();
		test_centre_stop();
		test_prescale_edges();
		test_backpressure();

		test_random_run(16'd1, 16'd0, 16'd0, 150, RX_COIN, 4);
		test_random_run(16'd1, 16'hFFFF, 16'h00FF, 200, RX_OPEN, 0);
		test_random_run(16'd2, 16'd6, 16'hA50C, 200, RX_COMB, 3);
		test_random_run(16'd3, 16'd40, 16'd30, 180, RX_COIN, 8);
		test_random_run(16'hFFFF, 16'd1, 16'd200, 80, RX_OPEN, 2);
		test_random_run(16'd100, 16'd500, 16'd93, 220, RX_COMB, 4);
		test_random_run(16'd1, 16'd3, 16'h5A07, 150, RX_COIN, 20);

		if (drive_q.size() != 0) begin
			$error("%0d results never arrived", drive_q.size());
			errors++;
		end
		$display("run: %0d requests, %0d results, %0d samples, %0d controller stops",
			requests, results, samples, stops);
		$display("settings swept from divide 0 to 65535, window 0 to 65535, limit 0 to 255");
		if (errors == 0)
			$display("line_follow_stepper_controller verification clean");
		else
			$display("line_follow_stepper_controller verification failed");
		$finish;
	end

endmodule
